>>> rtl/flha_pkg.sv
// Shared constants for the free-list heap allocator.
package flha_pkg;

  parameter int ARENA_UNITS_DEF = 65536;
  parameter int MIN_GROW_DEF    = 1024;
  parameter int UNIT_BYTES_DEF  = 16;

  parameter int BYTES_W   = 21;
  parameter int UNIT_W    = 16;
  parameter int IN_DATA_W = 40;
  parameter int PAY_W     = 16;

endpackage

>>> rtl/flha_ram.sv
// Generic single-port RAM with registered read.
module flha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic                     we_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/free_list_heap_allocator.sv
// Next-fit free-list heap allocator over an arena of fixed-size units.
//
// Input stream: one beat per request. tuser is the request kind (0 allocate,
// 1 free); tdata carries the byte count and the payload unit to free.
// Output stream: one beat per request. tdata is the payload unit of an
// allocated block (0 for a free or a failed allocate), tuser is ok.
// A request is taken only when the previous one is finished; the result
// register lets the next request enter while a result still waits.
// An allocate rounds bytes to units with a shift (UNIT_BYTES is a
// power of two), then walks the free list from the rover and takes an
// exact fit or splits a larger node; each heap growth adds a free walk.
// A free walks to its insertion point and merges with its neighbours.
// Both walks chase links through the header memory, one read per cycle.
// Reset empties the list and the break; the header memory is not cleared,
// since every header is written before it is read. When the receiver
// stalls, the finished result holds in the output register and the next
// request completes into a hold state until that beat leaves.
module free_list_heap_allocator #(
  parameter int ARENA_UNITS = flha_pkg::ARENA_UNITS_DEF,
  parameter int MIN_GROW    = flha_pkg::MIN_GROW_DEF,
  parameter int UNIT_BYTES  = flha_pkg::UNIT_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // alloc_bytes [20:0], free_unit [36:21], zero [39:37]
  input  logic [flha_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // req_type [0]
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // payload_unit [15:0]
  output logic [flha_pkg::PAY_W-1:0]     m_axis_tdata,
  // ok [0]
  output logic                           m_axis_tuser
);
  import flha_pkg::*;

  localparam int AW    = $clog2(ARENA_UNITS);
  localparam int LW    = AW + 1;
  localparam int NW    = 22;
  localparam int SH    = $clog2(UNIT_BYTES);
  localparam int LIMIT = 2 * ARENA_UNITS + 4;
  localparam int SW    = $clog2(LIMIT + 2);
  localparam logic [LW-1:0] SENT = LW'(ARENA_UNITS);
  localparam logic [SW-1:0] LIM  = SW'(LIMIT);

  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    S_DIV     = 16'h0002,
    S_A_RD    = 16'h0004,
    S_A_P0    = 16'h0008,
    S_A_CHK   = 16'h0010,
    S_A_EXACT = 16'h0020,
    S_A_SPLIT = 16'h0040,
    S_A_SPL2  = 16'h0080,
    S_A_GROW  = 16'h0100,
    S_R_RD    = 16'h0200,
    S_R_WALK  = 16'h0400,
    S_R_RDB   = 16'h0800,
    S_R_RDQ   = 16'h1000,
    S_R_MRG   = 16'h2000,
    S_R_WP    = 16'h4000,
    S_RES     = 16'h8000
  } state_e;

  state_e state_q, state_d;

  logic [LW-1:0]    rover_q, rover_d, sent_q, sent_d, heap_q, heap_d;
  logic             started_q, started_d, m_valid_q, m_valid_d;
  logic [NW-1:0]    x_q, x_d, need_q, need_d;
  logic [LW-1:0]    p_q, p_d, prev_q, prev_d, q_q, q_d, b_q, b_d;
  logic [LW-1:0]    rest_q, rest_d, plink_q, plink_d, psz_q, psz_d, bsz_q, bsz_d;
  logic [LW-1:0]    nbsz_q, nbsz_d, nbln_q, nbln_d, grow_q, grow_d, rd_idx_q;
  logic [SW-1:0]    a_steps_q, a_steps_d, w_steps_q, w_steps_d;
  logic             ret_alloc_q, ret_alloc_d, res_ok_q, res_ok_d, m_user_q, m_user_d;
  logic [PAY_W-1:0] res_pay_q, res_pay_d, m_data_q, m_data_d;

  logic [LW-1:0]    addr_idx, link_wd, size_wd, link_rd, size_rd, cur_link, cur_size;
  logic             link_we, size_we, rel_ret;
  logic [NW-1:0]    grow_c;
  logic [LW-1:0]    kp, kq, kb;
  logic             brk, merge;

  logic                 in_kind;
  logic [BYTES_W-1:0]   in_bytes;
  logic [UNIT_W-1:0]    in_unit;

  assign in_kind  = s_axis_tuser;
  assign in_bytes = s_axis_tdata[BYTES_W-1:0];
  assign in_unit  = s_axis_tdata[BYTES_W+UNIT_W-1:BYTES_W];

  function automatic logic [LW-1:0] okey(input logic [LW-1:0] i);
    okey = (i >= SENT) ? '0 : i + LW'(1);
  endfunction

  flha_ram #(.WIDTH(LW), .DEPTH(ARENA_UNITS)) u_link_ram (
    .clk_i   (clk_i),
    .addr_i  (addr_idx[AW-1:0]),
    .we_i    (link_we),
    .wdata_i (link_wd),
    .rdata_o (link_rd)
  );

  flha_ram #(.WIDTH(LW), .DEPTH(ARENA_UNITS)) u_size_ram (
    .clk_i   (clk_i),
    .addr_i  (addr_idx[AW-1:0]),
    .we_i    (size_we),
    .wdata_i (size_wd),
    .rdata_o (size_rd)
  );

  assign cur_link = (rd_idx_q >= SENT) ? sent_q : ((link_rd < SENT) ? link_rd : SENT);
  assign cur_size = (rd_idx_q >= SENT) ? '0 : size_rd;

  assign grow_c  = (need_q < NW'(MIN_GROW)) ? NW'(MIN_GROW) : need_q;

  assign kp    = okey(p_q);
  assign kq    = okey(cur_link);
  assign kb    = okey(b_q);
  assign brk   = ((kb > kp) && (kb < kq)) || ((kp >= kq) && ((kb > kp) || (kb < kq)));
  assign merge = (q_q != SENT) && ((LW+1)'(b_q) + (LW+1)'(bsz_q) == (LW+1)'(q_q));

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  always_comb begin
    state_d     = state_q;
    rover_d     = rover_q;
    sent_d      = sent_q;
    heap_d      = heap_q;
    started_d   = started_q;
    m_valid_d   = m_valid_q;
    x_d         = x_q;
    need_d      = need_q;
    p_d         = p_q;
    prev_d      = prev_q;
    q_d         = q_q;
    b_d         = b_q;
    rest_d      = rest_q;
    plink_d     = plink_q;
    psz_d       = psz_q;
    bsz_d       = bsz_q;
    nbsz_d      = nbsz_q;
    nbln_d      = nbln_q;
    grow_d      = grow_q;
    a_steps_d   = a_steps_q;
    w_steps_d   = w_steps_q;
    ret_alloc_d = ret_alloc_q;
    res_ok_d    = res_ok_q;
    res_pay_d   = res_pay_q;
    m_data_d    = m_data_q;
    m_user_d    = m_user_q;
    addr_idx    = rd_idx_q;
    link_we     = 1'b0;
    size_we     = 1'b0;
    link_wd     = b_q;
    size_wd     = nbsz_q;
    rel_ret     = 1'b0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          if (!in_kind) begin
            x_d     = NW'(in_bytes) + NW'(UNIT_BYTES - 1);
            state_d = S_DIV;
          end else if ((in_unit != '0) && (NW'(in_unit) - NW'(1) < NW'(heap_q))) begin
            b_d         = LW'(NW'(in_unit) - NW'(1));
            ret_alloc_d = 1'b0;
            state_d     = S_R_RD;
          end else begin
            res_pay_d = '0;
            res_ok_d  = 1'b1;
            state_d   = S_RES;
          end
        end
      end
      S_DIV: begin
        need_d    = (x_q >> SH) + NW'(1);
        a_steps_d = '0;
        if (!started_q) begin
          sent_d    = SENT;
          rover_d   = SENT;
          started_d = 1'b1;
        end
        state_d = S_A_RD;
      end
      S_A_RD: begin
        addr_idx = rover_q;
        state_d  = S_A_P0;
      end
      S_A_P0: begin
        prev_d   = rd_idx_q;
        p_d      = cur_link;
        addr_idx = cur_link;
        state_d  = S_A_CHK;
      end
      S_A_CHK: begin
        if (NW'(cur_size) >= need_q) begin
          if (NW'(cur_size) == need_q) begin
            plink_d = cur_link;
            state_d = S_A_EXACT;
          end else begin
            rest_d  = cur_size - LW'(need_q);
            state_d = S_A_SPLIT;
          end
        end else if (p_q == rover_q) begin
          if (NW'(heap_q) + grow_c > NW'(ARENA_UNITS)) begin
            res_pay_d = '0;
            res_ok_d  = 1'b0;
            state_d   = S_RES;
          end else begin
            grow_d  = LW'(grow_c);
            state_d = S_A_GROW;
          end
        end else if (a_steps_q >= LIM) begin
          res_pay_d = '0;
          res_ok_d  = 1'b0;
          state_d   = S_RES;
        end else begin
          prev_d    = p_q;
          p_d       = cur_link;
          addr_idx  = cur_link;
          a_steps_d = a_steps_q + SW'(1);
        end
      end
      S_A_EXACT: begin
        if (prev_q >= SENT) begin
          sent_d = plink_q;
        end else begin
          addr_idx = prev_q;
          link_we  = 1'b1;
          link_wd  = plink_q;
        end
        rover_d   = prev_q;
        res_pay_d = PAY_W'(NW'(p_q) + NW'(1));
        res_ok_d  = 1'b1;
        state_d   = S_RES;
      end
      S_A_SPLIT: begin
        addr_idx = p_q;
        size_we  = (p_q < SENT);
        size_wd  = rest_q;
        p_d      = p_q + rest_q;
        state_d  = S_A_SPL2;
      end
      S_A_SPL2: begin
        addr_idx  = p_q;
        size_we   = (p_q < SENT);
        size_wd   = LW'(need_q);
        rover_d   = prev_q;
        res_pay_d = PAY_W'(NW'(p_q) + NW'(1));
        res_ok_d  = 1'b1;
        state_d   = S_RES;
      end
      S_A_GROW: begin
        addr_idx    = heap_q;
        size_we     = (heap_q < SENT);
        size_wd     = grow_q;
        b_d         = heap_q;
        heap_d      = heap_q + grow_q;
        ret_alloc_d = 1'b1;
        state_d     = S_R_RD;
      end
      S_R_RD: begin
        addr_idx  = rover_q;
        p_d       = rover_q;
        w_steps_d = '0;
        state_d   = S_R_WALK;
      end
      S_R_WALK: begin
        if (brk) begin
          q_d     = cur_link;
          psz_d   = cur_size;
          state_d = S_R_RDB;
        end else if (w_steps_q >= LIM) begin
          rel_ret = 1'b1;
        end else begin
          p_d       = cur_link;
          addr_idx  = cur_link;
          w_steps_d = w_steps_q + SW'(1);
        end
      end
      S_R_RDB: begin
        addr_idx = b_q;
        state_d  = S_R_RDQ;
      end
      S_R_RDQ: begin
        bsz_d    = cur_size;
        addr_idx = q_q;
        state_d  = S_R_MRG;
      end
      S_R_MRG: begin
        nbsz_d   = merge ? bsz_q + cur_size : bsz_q;
        nbln_d   = merge ? cur_link : q_q;
        addr_idx = b_q;
        link_we  = (b_q < SENT);
        size_we  = (b_q < SENT);
        link_wd  = merge ? cur_link : q_q;
        size_wd  = merge ? bsz_q + cur_size : bsz_q;
        state_d  = S_R_WP;
      end
      S_R_WP: begin
        if ((p_q < SENT) && ((LW+1)'(p_q) + (LW+1)'(psz_q) == (LW+1)'(b_q))) begin
          addr_idx = p_q;
          link_we  = 1'b1;
          size_we  = 1'b1;
          link_wd  = nbln_q;
          size_wd  = psz_q + nbsz_q;
        end else if (p_q >= SENT) begin
          sent_d = b_q;
        end else begin
          addr_idx = p_q;
          link_we  = 1'b1;
          link_wd  = b_q;
        end
        rover_d = p_q;
        rel_ret = 1'b1;
      end
      S_RES: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = res_pay_q;
          m_user_d  = res_ok_q;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (rel_ret) begin
      if (!ret_alloc_q) begin
        res_pay_d = '0;
        res_ok_d  = 1'b1;
        state_d   = S_RES;
      end else if (a_steps_q >= LIM) begin
        res_pay_d = '0;
        res_ok_d  = 1'b0;
        state_d   = S_RES;
      end else begin
        a_steps_d = a_steps_q + SW'(1);
        state_d   = S_A_RD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rover_q   <= SENT;
      sent_q    <= SENT;
      heap_q    <= '0;
      started_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rover_q   <= rover_d;
      sent_q    <= sent_d;
      heap_q    <= heap_d;
      started_q <= started_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q         <= x_d;
    need_q      <= need_d;
    p_q         <= p_d;
    prev_q      <= prev_d;
    q_q         <= q_d;
    b_q         <= b_d;
    rest_q      <= rest_d;
    plink_q     <= plink_d;
    psz_q       <= psz_d;
    bsz_q       <= bsz_d;
    nbsz_q      <= nbsz_d;
    nbln_q      <= nbln_d;
    grow_q      <= grow_d;
    a_steps_q   <= a_steps_d;
    w_steps_q   <= w_steps_d;
    ret_alloc_q <= ret_alloc_d;
    res_ok_q    <= res_ok_d;
    res_pay_q   <= res_pay_d;
    m_data_q    <= m_data_d;
    m_user_q    <= m_user_d;
    rd_idx_q    <= addr_idx;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    heap_q <= SENT)
    else $error("heap break beyond arena");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (link_we || size_we) |-> (addr_idx < SENT))
    else $error("header write outside arena");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_user_q) |-> (m_data_q == '0))
    else $error("failed allocate carries a payload unit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rover_q <= SENT)
    else $error("rover outside arena");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RES && m_valid_q && !m_axis_tready) |=> (state_q == S_RES))
    else $error("result dropped under stall");

endmodule

>>> tb/tb_free_list_heap_allocator.sv
// Self-checking testbench for the free-list heap allocator stream block.
`timescale 1ns / 100ps

module tb_free_list_heap_allocator;
  import flha_pkg::*;

  localparam int unsigned ARENA  = ARENA_UNITS_DEF;
  localparam int unsigned SENT   = ARENA_UNITS_DEF;
  localparam int unsigned GROW   = MIN_GROW_DEF;
  localparam int unsigned UBYTES = UNIT_BYTES_DEF;
  localparam int unsigned WALK_MAX = 2 * ARENA_UNITS_DEF + 4;
  localparam bit REQ_ALLOC = 1'b0;
  localparam bit REQ_FREE  = 1'b1;
  localparam int IDLE_PCT  = 22;

  typedef struct packed {
    logic               kind;
    logic [BYTES_W-1:0] bytes;
    logic [UNIT_W-1:0]  unit;
  } req_t;

  typedef struct packed {
    logic [PAY_W-1:0] pay;
    logic             ok;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [PAY_W-1:0] m_axis_tdata;
  logic m_axis_tuser;

  free_list_heap_allocator dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Allocator shadow state.
  int unsigned hdr_next [ARENA];
  int unsigned hdr_size [ARENA];
  bit          hdr_wr   [ARENA];
  int unsigned head_next = SENT;
  int unsigned rover = SENT;
  bit          started = 1'b0;
  int unsigned brk = 0;

  req_t pending_reqs[$];
  res_t expected_res[$];
  int unsigned live_blocks[$];
  int errors = 0;
  int sent_cnt = 0;
  int got_cnt = 0;
  bit in_fire = 1'b0;
  int hold_cycles = 0;
  bit hold_done = 1'b0;

  function automatic int unsigned order_of(int unsigned i);
    return (i >= SENT) ? 0 : i + 1;
  endfunction

  function automatic int unsigned link_at(int unsigned i);
    if (i == SENT) return head_next;
    if (i > SENT) return SENT;
    return (hdr_next[i] < SENT) ? hdr_next[i] : SENT;
  endfunction

  function automatic int unsigned size_at(int unsigned i);
    return (i < SENT) ? hdr_size[i] : 0;
  endfunction

  function automatic void put_link(int unsigned i, int unsigned v);
    if (i == SENT) head_next = v;
    else if (i < SENT) begin
      hdr_next[i] = v;
      hdr_wr[i] = 1'b1;
    end
  endfunction

  function automatic void put_size(int unsigned i, int unsigned v);
    if (i < SENT) begin
      hdr_size[i] = v;
      hdr_wr[i] = 1'b1;
    end
  endfunction

  function automatic void insert_free(int unsigned b);
    int unsigned p, q, kb, kp, kq, steps;
    p = rover;
    kb = order_of(b);
    steps = 0;
    forever begin
      q = link_at(p);
      kp = order_of(p);
      kq = order_of(q);
      if (kb > kp && kb < kq) break;
      if (kp >= kq && (kb > kp || kb < kq)) break;
      p = q;
      steps++;
      if (steps > WALK_MAX) return;
    end
    q = link_at(p);
    if (q != SENT && longint'(b) + size_at(b) == q) begin
      put_size(b, size_at(b) + size_at(q));
      put_link(b, link_at(q));
    end else begin
      put_link(b, q);
    end
    if (p != SENT && longint'(p) + size_at(p) == b) begin
      put_size(p, size_at(p) + size_at(b));
      put_link(p, link_at(b));
    end else begin
      put_link(p, b);
    end
    rover = p;
  endfunction

  // Returns full payload unit (header + 1), 0 on failure.
  function automatic int unsigned take_block(longint unsigned bytes, output bit good);
    longint unsigned need, grow;
    int unsigned prv, p, s, rest, h, steps;
    need = (bytes + UBYTES - 1) / UBYTES + 1;
    good = 1'b0;
    steps = 0;
    if (!started) begin
      head_next = SENT;
      rover = SENT;
      started = 1'b1;
    end
    prv = rover;
    p = link_at(prv);
    forever begin
      s = size_at(p);
      if (longint'(s) >= need) begin
        if (longint'(s) == need) begin
          put_link(prv, link_at(p));
        end else begin
          rest = s - int'(need);
          put_size(p, rest);
          p = p + rest;
          put_size(p, int'(need));
        end
        rover = prv;
        good = 1'b1;
        return p + 1;
      end
      if (p == rover) begin
        grow = (need < GROW) ? GROW : need;
        h = brk;
        if (longint'(brk) + grow > ARENA) return 0;
        put_size(h, int'(grow));
        brk = brk + int'(grow);
        insert_free(h);
        p = rover;
      end
      prv = p;
      p = link_at(p);
      steps++;
      if (steps > WALK_MAX) return 0;
    end
  endfunction

  function automatic int unsigned issue(bit kind, int unsigned bytes, int unsigned unit);
    req_t r;
    res_t e;
    bit good;
    int unsigned pay;
    pay = 0;
    r.kind = kind;
    r.bytes = bytes[BYTES_W-1:0];
    r.unit = unit[UNIT_W-1:0];
    if (kind == REQ_ALLOC) begin
      pay = take_block(r.bytes, good);
      e.pay = good ? pay[PAY_W-1:0] : '0;
      e.ok = good;
      if (good && pay < SENT) live_blocks.push_back(pay);
    end else begin
      if (r.unit != 0 && r.unit - 1 < brk) insert_free(r.unit - 1);
      e.pay = '0;
      e.ok = 1'b1;
    end
    pending_reqs.push_back(r);
    expected_res.push_back(e);
    return pay;
  endfunction

  task automatic release_live(int idx);
    int unsigned u;
    u = live_blocks[idx];
    live_blocks.delete(idx);
    void'(issue(REQ_FREE, 0, u));
  endtask

  task automatic drain();
    wait (pending_reqs.size() == 0 && expected_res.size() == 0);
    @(posedge clk_i);
  endtask

  // Driver: present beats at the falling edge.
  always @(posedge clk_i) in_fire <= s_axis_tvalid && s_axis_tready;

  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      if (pending_reqs.size() != 0 &&
          ((sent_cnt > 300 && sent_cnt < 550) || $urandom_range(99) >= IDLE_PCT)) begin
        req_t r;
        r = pending_reqs.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= r.kind;
        s_axis_tdata <= {3'b000, r.unit, r.bytes};
        sent_cnt++;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && got_cnt >= 700) begin
        hold_done <= 1'b1;
        hold_cycles <= 400;
        m_axis_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (got_cnt > 1000 && got_cnt < 1250) ||
                         ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_cnt++;
      if (expected_res.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat pay=%0d ok=%0d", $time, m_axis_tdata, m_axis_tuser);
      end else begin
        res_t e;
        e = expected_res.pop_front();
        if (m_axis_tdata !== e.pay) begin
          errors++;
          $display("%0t: payload_unit expected %0d actual %0d", $time, e.pay, m_axis_tdata);
        end
        if (m_axis_tuser !== e.ok) begin
          errors++;
          $display("%0t: ok expected %0d actual %0d", $time, e.ok, m_axis_tuser);
        end
      end
    end
  end

  initial begin
    #200_000_000;
    $display("tb_free_list_heap_allocator: FAIL");
    $finish;
  end

  initial begin
    int unsigned u, n, pick;
    int r;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: zero bytes, rounding edges, exhaustion, ignored frees.
    void'(issue(REQ_ALLOC, 0, 0));
    void'(issue(REQ_ALLOC, 1, 0));
    void'(issue(REQ_ALLOC, 16, 0));
    void'(issue(REQ_ALLOC, 17, 0));
    void'(issue(REQ_ALLOC, 1048576, 0));
    void'(issue(REQ_ALLOC, 2097151, 0));
    void'(issue(REQ_ALLOC, 20000, 0));
    void'(issue(REQ_FREE, 0, 0));
    void'(issue(REQ_FREE, 0, 65535));
    void'(issue(REQ_FREE, 0, brk + 1));
    void'(issue(REQ_ALLOC, 15, 0));
    release_live(0);
    release_live(live_blocks.size() - 1);
    release_live(1);
    void'(issue(REQ_ALLOC, 1000, 0));
    void'(issue(REQ_ALLOC, 1, 0));
    drain();

    for (int i = 0; i < 1640; i++) begin
      r = $urandom_range(99);
      if (r < 50 && live_blocks.size() < 40 || r < 85 && live_blocks.size() == 0) begin
        case ($urandom_range(4))
          0, 1: n = $urandom_range(64);
          2, 3: n = $urandom_range(1000);
          default: n = $urandom_range(16000);
        endcase
        void'(issue(REQ_ALLOC, n, 0));
      end else if (r < 85) begin
        release_live($urandom_range(live_blocks.size() - 1));
      end else if (r < 92) begin
        void'(issue(REQ_ALLOC, $urandom_range(2097151), 0));
      end else if (r < 96 || brk >= 65535) begin
        void'(issue(REQ_FREE, $urandom, 0));
      end else begin
        void'(issue(REQ_FREE, $urandom, $urandom_range(65535, brk + 1)));
      end
      if (i == 820) drain();
    end

    // Return everything, then fill the arena so a one-unit block lands on top.
    while (live_blocks.size() != 0) release_live($urandom_range(live_blocks.size() - 1));
    if (brk < 32768) begin
      n = ARENA - brk;
      pick = issue(REQ_ALLOC, (n - 1) * UBYTES, 0);
      if (pick != 0) release_live(live_blocks.size() - 1);
      void'(issue(REQ_ALLOC, 0, 0));
    end
    drain();

    // Double free breaks the list; the walks must give up the same way.
    void'(issue(REQ_ALLOC, 100, 0));
    void'(issue(REQ_ALLOC, 100, 0));
    if (live_blocks.size() != 0) begin
      u = live_blocks[live_blocks.size() - 1];
      release_live(live_blocks.size() - 1);
      void'(issue(REQ_FREE, 0, u));
      void'(issue(REQ_ALLOC, 40, 0));
      void'(issue(REQ_FREE, 0, u));
    end

    drain();
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_free_list_heap_allocator: PASS");
    end else begin
      $display("tb_free_list_heap_allocator: FAIL");
    end
    $finish;
  end

endmodule
